### rtl/critically_damped_spring_smoother_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CRITICALLY_DAMPED_SPRING_SMOOTHER_TOP_ASSERT_SVH
`define CRITICALLY_DAMPED_SPRING_SMOOTHER_TOP_ASSERT_SVH
// Implication checked on every edge, off during reset.
`define CDS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, off during reset.
`define CDS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### rtl/cds_pkg.sv
package cds_pkg;
  localparam int FB = 16;
  localparam logic [31:0] ONE_RAW = 32'd65536;
  localparam logic [31:0] TINY_RAW = 32'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_BLEND, S_BLEND_W, S_DIV, S_POW_INIT, S_POW, S_ALPHA, S_DAMP, S_DAMP_W,
    S_SQRT, S_ACC1, S_ACC1_W, S_ACC2, S_ACC2_W, S_NV, S_NV_W, S_RES, S_RES_W,
    S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    logic mul_wr;
    logic [2:0] mul_sel;
    logic div_go;
    logic pow_init;
    logic pow_step;
    logic alpha_set;
    logic sqrt_go;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic dt_tiny;
    logic spring_tiny;
    logic unit_busy;
    logic pow_done;
  } sts_t;

  localparam logic [2:0] M_BLEND = 3'd0;
  localparam logic [2:0] M_DAMP = 3'd1;
  localparam logic [2:0] M_ACC1 = 3'd2;
  localparam logic [2:0] M_ACC2 = 3'd3;
  localparam logic [2:0] M_NV = 3'd4;
  localparam logic [2:0] M_RES = 3'd5;

  localparam logic [1:0] R_INERTIA = 2'd0;
  localparam logic [1:0] R_HALF = 2'd1;
  localparam logic [1:0] R_SPRING = 2'd2;
  localparam logic [1:0] R_SPEED = 2'd3;

  // round-to-nearest, ties away, rescale by 2^FB of a signed 66-bit magnitude product
  function automatic logic signed [65:0] rnd_shift(input logic neg, input logic [65:0] mag);
    logic [65:0] r;
    r = (mag + 66'(1 << (FB - 1))) >> FB;
    return neg ? -$signed(r) : $signed(r);
  endfunction
endpackage

### rtl/cds_ctrl.sv
module cds_ctrl import cds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_stall,
  input  sts_t sts,
  output logic in_stall,
  output logic out_valid,
  output cmd_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_BLEND;
      end
      S_BLEND: begin
        if (sts.dt_tiny) begin
          state_next = S_OUT;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_sel = M_BLEND;
          cmd.div_go = 1'b1;
          state_next = S_BLEND_W;
        end
      end
      S_BLEND_W: begin
        cmd.mul_wr = 1'b1;
        cmd.mul_sel = M_BLEND;
        state_next = S_DIV;
      end
      S_DIV: if (!sts.unit_busy) state_next = S_POW_INIT;
      S_POW_INIT: begin
        cmd.pow_init = 1'b1;
        state_next = S_POW;
      end
      S_POW: begin
        if (sts.pow_done) state_next = S_ALPHA;
        else cmd.pow_step = 1'b1;
      end
      S_ALPHA: begin
        cmd.alpha_set = 1'b1;
        state_next = S_DAMP;
      end
      S_DAMP: begin
        cmd.mul_go = 1'b1;
        cmd.mul_sel = M_DAMP;
        state_next = S_DAMP_W;
      end
      S_DAMP_W: begin
        cmd.mul_wr = 1'b1;
        cmd.mul_sel = M_DAMP;
        if (sts.spring_tiny) begin
          state_next = S_FIN;
        end else begin
          cmd.sqrt_go = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: if (!sts.unit_busy) state_next = S_ACC1;
      S_ACC1: begin
        cmd.mul_go = 1'b1;
        cmd.mul_sel = M_ACC1;
        state_next = S_ACC1_W;
      end
      S_ACC1_W: begin
        cmd.mul_wr = 1'b1;
        cmd.mul_sel = M_ACC1;
        state_next = S_ACC2;
      end
      S_ACC2: begin
        cmd.mul_go = 1'b1;
        cmd.mul_sel = M_ACC2;
        state_next = S_ACC2_W;
      end
      S_ACC2_W: begin
        cmd.mul_wr = 1'b1;
        cmd.mul_sel = M_ACC2;
        state_next = S_NV;
      end
      S_NV: begin
        cmd.mul_go = 1'b1;
        cmd.mul_sel = M_NV;
        state_next = S_NV_W;
      end
      S_NV_W: begin
        cmd.mul_wr = 1'b1;
        cmd.mul_sel = M_NV;
        state_next = S_RES;
      end
      S_RES: begin
        cmd.mul_go = 1'b1;
        cmd.mul_sel = M_RES;
        state_next = S_RES_W;
      end
      S_RES_W: begin
        cmd.mul_wr = 1'b1;
        cmd.mul_sel = M_RES;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### rtl/cds_dp.sv
module cds_dp import cds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic signed [31:0] target,
  input  logic [15:0] delta_time,
  input  logic clear,
  input  logic [16:0] inertia,
  input  logic [23:0] damping_half_life,
  input  logic [31:0] spring_strength,
  input  logic [30:0] max_speed,
  output logic signed [31:0] smoothed_value,
  output logic signed [31:0] velocity_out
);
  logic signed [31:0] cur, vel, tgt;
  logic [15:0] dt;
  logic signed [65:0] itgt, dtgt, acc1, nv, res;
  logic [16:0] alpha;
  logic [39:0] quo, rem, dvd;
  logic [5:0] cnt;
  logic busy, is_sqrt;
  logic [63:0] sx, sr, sbit;
  logic [31:0] pw, cc;
  logic [4:0] pk;
  logic [1:0] pph;
  logic [63:0] cx, cr, cbit;
  logic signed [33:0] crit;

  // shared multiplier: low 25 x 34 partial product on mul_go, high one and
  // writeback on mul_wr; operands hold from mul_go through mul_wr
  logic signed [65:0] ma;
  logic [33:0] mb;
  logic [65:0] mag, prod;
  logic [58:0] plo_c, phi, plo;
  logic signed [65:0] pres;
  logic [16:0] inr;

  assign inr = (inertia > 17'(ONE_RAW)) ? 17'(ONE_RAW) : inertia;
  assign sts.dt_tiny = ({16'd0, dt} <= TINY_RAW);
  assign sts.spring_tiny = (spring_strength <= TINY_RAW);
  assign sts.unit_busy = busy;
  assign sts.pow_done = (pk == 5'd17);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      M_BLEND: begin ma = 66'(tgt) - 66'(cur); mb = 34'(17'(ONE_RAW) - inr); end
      M_DAMP: begin ma = itgt - 66'(cur); mb = 34'(alpha); end
      M_ACC1: begin ma = dtgt - 66'(cur); mb = 34'(spring_strength); end
      M_ACC2: begin ma = 66'(vel); mb = 34'(crit); end
      M_NV: begin ma = acc1; mb = 34'(dt); end
      M_RES: begin ma = nv; mb = 34'(dt); end
      default: ;
    endcase
    mag = ma[65] ? 66'(-ma) : 66'(ma);
    plo_c = 59'(mag[24:0]) * 59'(mb);
    phi = 59'(mag[49:25]) * 59'(mb);
    prod = 66'(plo) + (66'(phi) << 25);
    pres = rnd_shift(ma[65], prod);
  end

  logic signed [65:0] acc_c, nvs, lo, hi, pad, diff, rc, curx, tgtx;
  logic signed [65:0] ms;
  always_comb begin
    acc_c = acc1 - pres;
    if (acc_c > 66'sd140737488355328) acc_c = 66'sd140737488355328;
    if (acc_c < -66'sd140737488355328) acc_c = -66'sd140737488355328;
    nvs = 66'(vel) + pres;
    if (nvs > 66'sd2147483647) nvs = 66'sd2147483647;
    if (nvs < -66'sd2147483648) nvs = -66'sd2147483648;
    ms = 66'(max_speed);
    if (ms != 0) begin
      if (nvs > ms) nvs = ms;
      if (nvs < -ms) nvs = -ms;
    end
    curx = 66'(cur);
    tgtx = 66'(tgt);
    diff = tgtx - curx;
    pad = diff[65] ? -diff : diff;
    if (pad < 66'(ONE_RAW)) pad = 66'(ONE_RAW);
    lo = ((curx < tgtx) ? curx : tgtx) - pad;
    hi = ((curx > tgtx) ? curx : tgtx) + pad;
    rc = res;
    if (rc < lo) rc = lo;
    if (rc > hi) rc = hi;
  end

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      vel <= '0;
      busy <= 1'b0;
      pk <= '0;
    end else begin
      if (cmd.load) begin
        tgt <= target;
        dt <= delta_time;
        if (clear) begin
          cur <= '0;
          vel <= '0;
        end
      end
      if (cmd.mul_go) plo <= plo_c;
      if (cmd.mul_wr) begin
        case (cmd.mul_sel)
          M_BLEND: itgt <= 66'(cur) + pres;
          M_DAMP: dtgt <= 66'(cur) + pres;
          M_ACC1: acc1 <= pres;
          M_ACC2: acc1 <= acc_c;
          M_NV: nv <= nvs;
          M_RES: res <= 66'(cur) + pres;
          default: ;
        endcase
      end
      // restoring divider: (dt << FB) / hl, one quotient bit per cycle
      if (cmd.div_go) begin
        busy <= 1'b1;
        is_sqrt <= 1'b0;
        dvd <= 40'({dt, 16'd0});
        rem <= '0;
        quo <= '0;
        cnt <= 6'd32;
      end else if (cmd.sqrt_go) begin
        busy <= 1'b1;
        is_sqrt <= 1'b1;
        sx <= 64'({spring_strength, 16'd0});
        sr <= '0;
        sbit <= 64'd1 << 62;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) busy <= 1'b0;
        if (is_sqrt) begin
          if (sx >= sr + sbit) begin
            sx <= sx - (sr + sbit);
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
          if (cnt == 6'd1) crit <= 34'(((sr >> 1) + ((sx >= sr + sbit) ? sbit : 64'd0)) << 1);
        end else begin
          logic [40:0] t;
          t = {rem[39:0], dvd[31]};
          dvd <= dvd << 1;
          if (t >= 41'(damping_half_life)) begin
            rem <= 40'(t - 41'(damping_half_life));
            quo <= {quo[38:0], 1'b1};
          end else begin
            rem <= t[39:0];
            quo <= {quo[38:0], 1'b0};
          end
        end
      end
      // power: pw = prod of the c_k whose quotient bit is set; each c_k = sqrt(c_{k-1} << 30) via bit-serial root
      if (cmd.pow_init) begin
        pw <= 32'd1 << 30;
        cc <= 32'd759250124;
        pk <= 5'd1;
        pph <= 2'd0;
      end else if (cmd.pow_step) begin
        case (pph)
          2'd0: begin
            if (quo[FB - 32'(pk)]) pw <= 32'((64'(pw) * 64'(cc) + (64'd1 << 29)) >> 30);
            cx <= 64'(cc) << 30;
            cr <= '0;
            cbit <= 64'd1 << 60;
            cnt <= 6'd31;
            pph <= 2'd1;
          end
          2'd1: begin
            if (cx >= cr + cbit) begin
              cx <= cx - (cr + cbit);
              cr <= (cr >> 1) + cbit;
            end else cr <= cr >> 1;
            cbit <= cbit >> 2;
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) pph <= 2'd2;
          end
          default: begin
            cc <= cr[31:0];
            pk <= pk + 5'd1;
            pph <= 2'd0;
          end
        endcase
      end
      if (cmd.alpha_set) begin
        logic [31:0] p;
        p = pw >> quo[20:16];
        p = (p + 32'd8192) >> 14;
        if (damping_half_life <= 24'(TINY_RAW) || quo[39:16] >= 24'd31) alpha <= 17'(ONE_RAW);
        else alpha <= 17'(ONE_RAW - p);
      end
      if (cmd.finish) begin
        if (sts.spring_tiny) begin
          vel <= '0;
          cur <= sat(dtgt);
        end else begin
          vel <= nv[31:0];
          cur <= sat(rc);
        end
      end
    end
  end

  assign smoothed_value = cur;
  assign velocity_out = vel;
endmodule

### rtl/critically_damped_spring_smoother_top.sv
// Critically damped spring smoother, one channel.
// Input beat: target (Q15.16), delta_time (Q0.16), clear. Accepted when
// in_valid is high and in_stall low. One output beat per input beat:
// smoothed_value and velocity_out, taken when out_valid high, out_stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index 0..3 (inertia, half-life,
// spring strength, max speed); cfg_ready is always high; write only while idle.
// With a tiny time step the beat goes straight to the output. Otherwise the
// work is the half-life divider, 16 exp2 factors (a 31-step square root per
// factor), the spring square root and the multiplies on the shared multiplier;
// a tiny spring skips the spring square root and the last four multiplies.
// One beat in flight at a time; in_stall stays high until the result leaves,
// so the next beat can be taken in the cycle after it. The time per beat is
// set mostly by the bit-serial roots of the exp2 chain.
// Synchronous reset (rst high) empties the block, zeroes config, value, velocity.
// While out_stall is high the result holds in place and no input is taken.
module critically_damped_spring_smoother_top import cds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] target,
  input  logic [15:0] delta_time,
  input  logic clear,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] smoothed_value,
  output logic signed [31:0] velocity_out,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  logic [16:0] inertia;
  logic [23:0] half_life;
  logic [31:0] spring;
  logic [30:0] max_speed;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // register file: drop bits above each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia <= '0;
      half_life <= '0;
      spring <= '0;
      max_speed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        R_INERTIA: inertia <= cfg_data[16:0];
        R_HALF: half_life <= cfg_data[23:0];
        R_SPRING: spring <= cfg_data;
        R_SPEED: max_speed <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  cds_ctrl u_ctrl (
    .clk, .rst, .in_valid, .out_stall, .sts, .in_stall, .out_valid, .cmd
  );

  cds_dp u_dp (
    .clk, .rst, .cmd, .sts, .target, .delta_time, .clear, .inertia,
    .damping_half_life(half_life), .spring_strength(spring), .max_speed,
    .smoothed_value, .velocity_out
  );
endmodule

### rtl/cds_checker.sv
`include "critically_damped_spring_smoother_top_assert.svh"
module cds_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [31:0] smoothed_value
);
  // an accepted beat closes the input (in_stall high) after it is taken
  `CDS_ASSERT_NEXT(a_busy, clk, rst, in_valid && !in_stall, in_stall)
  // never accept input while a result is pending
  `CDS_ASSERT_IMP(a_excl, clk, rst, out_valid, in_stall)
  // a stalled result holds
  `CDS_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(smoothed_value))
endmodule

bind critically_damped_spring_smoother_top cds_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .smoothed_value
);
